[hw/rtl/sba_pkg.sv]
// ============================================================================
// sba_pkg
// Shared types, constants and command codes of the striped bump allocator.
// ============================================================================
package sba_pkg;

    // Default parameter values for the top level.
    localparam int NUM_NODES_DEF  = 16;
    localparam int NODE_BYTES_DEF = 16777216;
    localparam int FREE_DEPTH_DEF = 256;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 7;
    localparam int HOME_W     = 8;
    localparam int HOME_SUM_W = 38;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // The bit of the APB address that selects a register.
    localparam int REG_SEL_BIT = 2;

    // Longest striped run, start of every bump pointer, and the number of
    // freed entries that must be exceeded before the free FIFO is reused.
    localparam int MAX_RUN     = 64;
    localparam int LOCAL_START = 64;
    localparam int RING_MIN    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOCAL  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_STRIPE = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_LOCAL_BASE = 1'b0,
        REG_HOME_NODE  = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCAL,
        ST_POP,
        ST_NODE_RD,
        ST_NODE_EL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] local_base;
        logic [HOME_W-1:0] home_node;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic push;
        logic pop_rd;
        logic stripe_init;
        logic loc_emit;
        logic pop_emit;
        logic node_rd;
        logic el_step;
        logic fin_emit;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_zero;
        logic             ring_gt_min;
        logic             el_last;
        logic             out_free;
    } t_stat;

endpackage

[hw/rtl/sba_req_if.sv]
// ============================================================================
// sba_req_if
// Request channel: one allocator command per item.
// ============================================================================
interface sba_req_if
    import sba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   size_bytes;
    logic [ADDR_W-1:0]   free_addr;
    logic [CNT_W-1:0]    elem_count;

    modport source (output valid, output cmd, output size_bytes, output free_addr,
                    output elem_count, input ready);
    modport sink   (input valid, input cmd, input size_bytes, input free_addr,
                    input elem_count, output ready);
endinterface

[hw/rtl/sba_rsp_if.sv]
// ============================================================================
// sba_rsp_if
// Response channel: one allocated address per item.
// ============================================================================
interface sba_rsp_if
    import sba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              last;
    logic              overflow;

    modport source (output valid, output address, output last, output overflow,
                    input ready);
    modport sink   (input valid, input address, input last, input overflow,
                    output ready);
endinterface

[hw/rtl/striped_bump_allocator_with_free_fifo.sv]
// ============================================================================
// striped_bump_allocator_with_free_fifo
// Address allocator with a local bump pointer, a FIFO of freed addresses and
// round-robin striped allocation across the node regions.
// ============================================================================
// Requests arrive as items on i_req (cmd, size_bytes, free_addr, elem_count)
// and allocated addresses leave as items on o_rsp (address, last, overflow).
// The APB port sets the local base and the home node; the user must write
// them only while the block is idle, which the block does not enforce.
// A free pushes its address into the FIFO and gives no item. A local alloc
// is accepted, then the address is placed in the output register once that
// register is free; it is the oldest freed address if the FIFO holds more
// than two entries, else the local bump pointer. A striped alloc of N
// elements (at most 64) is accepted, then each node pointer is read from RAM
// with a registered read and then bumped and written back, and the final
// address waits for the home-node bytes to be added to the local pointer.
// One request is worked on at a time, and i_req is ready only between
// requests, so the next request may enter while the last result still sits
// in the output register.
//
// After reset the local pointer is 64, every node pointer reads as its node
// offset plus 64 and the free FIFO is empty; no clearing pass is needed.
// When the receiver stalls, the output register holds its item and the
// sequencer waits with the next address until the register is free.
// ============================================================================
module striped_bump_allocator_with_free_fifo
    import sba_pkg::*;
#(
    parameter int NUM_NODES  = NUM_NODES_DEF,
    parameter int NODE_BYTES = NODE_BYTES_DEF,
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sba_req_if.sink            i_req,
    sba_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    t_cfg  s_cfg;
    t_ctl  s_ctl;
    t_stat s_stat;

    // Configuration registers behind the APB port.
    sba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // The sequencer decides what the datapath does in each cycle.
    sba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (s_stat),
        .o_ctl      (s_ctl)
    );

    // The datapath holds all allocator state and the result register.
    sba_dp #(
        .NUM_NODES  (NUM_NODES),
        .NODE_BYTES (NODE_BYTES),
        .FREE_DEPTH (FREE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (s_ctl),
        .o_stat       (s_stat),
        .i_cfg        (s_cfg),
        .i_cmd        (i_req.cmd),
        .i_size_bytes (i_req.size_bytes),
        .i_free_addr  (i_req.free_addr),
        .i_elem_count (i_req.elem_count),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_address    (o_rsp.address),
        .o_last       (o_rsp.last),
        .o_overflow   (o_rsp.overflow)
    );
endmodule

[hw/rtl/sba_ram.sv]
// ============================================================================
// sba_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

[hw/rtl/sba_cfg.sv]
// ============================================================================
// sba_cfg
// APB register file holding the local base and the home node.
// ============================================================================
module sba_cfg
    import sba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    logic [ADDR_W-1:0] r_local_base;
    logic [HOME_W-1:0] r_home_node;
    logic              s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_base <= '0;
            r_home_node  <= '0;
        end else if (s_wr) begin
            unique case (t_reg'(paddr[REG_SEL_BIT]))
                REG_LOCAL_BASE: r_local_base <= pwdata;
                REG_HOME_NODE:  r_home_node  <= pwdata[HOME_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[REG_SEL_BIT]))
            REG_LOCAL_BASE: prdata = r_local_base;
            REG_HOME_NODE:  prdata = PDATA_W'(r_home_node);
        endcase
    end

    assign o_cfg.local_base = r_local_base;
    assign o_cfg.home_node  = r_home_node;
endmodule

[hw/rtl/sba_ctrl.sv]
// ============================================================================
// sba_ctrl
// Sequencer that steps each command through the allocator datapath.
// ============================================================================
module sba_ctrl
    import sba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);
    t_state r_state;
    t_state n_state;
    logic   s_accept;

    assign s_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_stat.cmd)
                        CMD_LOCAL:  n_state = i_stat.ring_gt_min ? ST_POP : ST_LOCAL;
                        CMD_STRIPE: n_state = i_stat.cnt_zero ? ST_IDLE : ST_NODE_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOCAL, ST_POP: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NODE_RD: n_state = ST_NODE_EL;
            ST_NODE_EL: begin
                if (i_stat.el_last) begin
                    n_state = ST_FINISH;
                end else if (i_stat.out_free) begin
                    n_state = ST_NODE_RD;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_ctl.take        = s_accept;
                o_ctl.push        = s_accept && (i_stat.cmd == CMD_FREE);
                o_ctl.pop_rd      = s_accept && (i_stat.cmd == CMD_LOCAL)
                                    && i_stat.ring_gt_min;
                o_ctl.stripe_init = s_accept && (i_stat.cmd == CMD_STRIPE)
                                    && !i_stat.cnt_zero;
            end
            ST_LOCAL:   o_ctl.loc_emit = i_stat.out_free;
            ST_POP:     o_ctl.pop_emit = i_stat.out_free;
            ST_NODE_RD: o_ctl.node_rd  = 1'b1;
            ST_NODE_EL: o_ctl.el_step  = i_stat.el_last || i_stat.out_free;
            ST_FINISH:  o_ctl.fin_emit = i_stat.out_free;
            default:    o_ctl = '0;
        endcase
    end
endmodule

[hw/rtl/sba_dp.sv]
// ============================================================================
// sba_dp
// Allocator datapath: free FIFO, bump pointers and the result register.
// ============================================================================
module sba_dp
    import sba_pkg::*;
#(
    parameter int NUM_NODES  = NUM_NODES_DEF,
    parameter int NODE_BYTES = NODE_BYTES_DEF,
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    output t_stat             o_stat,
    input  t_cfg              i_cfg,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_size_bytes,
    input  logic [ADDR_W-1:0] i_free_addr,
    input  logic [CNT_W-1:0]  i_elem_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_address,
    output logic              o_last,
    output logic              o_overflow
);
    localparam int PW = $clog2(FREE_DEPTH);
    localparam int CW = $clog2(FREE_DEPTH + 1);
    localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

    // Free FIFO bookkeeping.
    logic [PW-1:0]     r_wp;
    logic [CW-1:0]     r_cnt;
    logic [CW:0]       s_off;
    logic [PW-1:0]     s_spot;
    logic              s_push_ok;
    logic [ADDR_W-1:0] s_ring_q;

    // Bump pointers and the striped run.
    logic [ADDR_W-1:0]     r_local_next;
    logic [ADDR_W-1:0]     r_size;
    logic [CNT_W-1:0]      r_left;
    logic [NW-1:0]         r_node;
    logic [NUM_NODES-1:0]  r_nvld;
    logic                  r_nvld_q;
    logic [ADDR_W-1:0]     r_nrst;
    logic [ADDR_W-1:0]     s_node_q;
    logic [ADDR_W-1:0]     s_ptr;
    logic [ADDR_W:0]       s_nsum;
    logic                  s_novf;
    logic                  s_home_hit;
    logic [HOME_SUM_W-1:0] r_home;
    logic [ADDR_W-1:0]     r_pend_addr;
    logic                  r_pend_ovf;
    logic                  s_el_last;
    logic                  s_el_emit;

    // Local bump.
    logic [ADDR_W:0]       s_lsum;
    logic [HOME_SUM_W:0]   s_fsum;
    logic                  s_fovf;

    // Result register.
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_last;
    logic              r_out_ovf;
    logic              s_out_free;

    // Oldest entry sits count places behind the write position.
    always_comb begin
        s_off = (CW + 1)'(r_wp) + (CW + 1)'(FREE_DEPTH) - (CW + 1)'(r_cnt);
        if (s_off >= (CW + 1)'(FREE_DEPTH)) begin
            s_off = s_off - (CW + 1)'(FREE_DEPTH);
        end
        s_spot = s_off[PW-1:0];
    end

    assign s_push_ok = i_ctl.push && (r_cnt != CW'(FREE_DEPTH));

    sba_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (FREE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s_push_ok),
        .i_waddr (r_wp),
        .i_wdata (i_free_addr),
        .i_re    (i_ctl.pop_rd),
        .i_raddr (s_spot),
        .o_rdata (s_ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (s_push_ok) begin
            r_wp  <= (r_wp == PW'(FREE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end else if (i_ctl.pop_emit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Per-node pointers live in RAM; a node never written reads as its
    // start value, rebuilt from the node index alongside the RAM read.
    sba_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (i_ctl.el_step && !s_novf),
        .i_waddr (r_node),
        .i_wdata (s_nsum[ADDR_W-1:0]),
        .i_re    (i_ctl.node_rd),
        .i_raddr (r_node),
        .o_rdata (s_node_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.node_rd) begin
            r_nvld_q <= r_nvld[r_node];
            r_nrst   <= ADDR_W'(64'(r_node) * 64'(NODE_BYTES) + 64'(LOCAL_START));
        end
    end

    assign s_ptr      = r_nvld_q ? s_node_q : r_nrst;
    assign s_nsum     = {1'b0, s_ptr} + {1'b0, r_size};
    assign s_novf     = s_nsum[ADDR_W];
    assign s_home_hit = (HOME_W'(r_node) == i_cfg.home_node);
    assign s_el_last  = (r_left == CNT_W'(1));
    assign s_el_emit  = i_ctl.el_step && !s_el_last;

    assign s_lsum = {1'b0, r_local_next} + {1'b0, r_size};
    assign s_fsum = (HOME_SUM_W + 1)'(r_local_next) + (HOME_SUM_W + 1)'(r_home);
    assign s_fovf = (s_fsum > (HOME_SUM_W + 1)'({ADDR_W{1'b1}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_next <= ADDR_W'(LOCAL_START);
            r_node       <= '0;
            r_nvld       <= '0;
        end else begin
            if (i_ctl.loc_emit && !s_lsum[ADDR_W]) begin
                r_local_next <= s_lsum[ADDR_W-1:0];
            end else if (i_ctl.fin_emit && !s_fovf) begin
                r_local_next <= s_fsum[ADDR_W-1:0];
            end
            if (i_ctl.el_step) begin
                r_node <= (r_node == NW'(NUM_NODES - 1)) ? '0 : r_node + 1'b1;
                if (!s_novf) begin
                    r_nvld[r_node] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_size <= i_size_bytes;
        end
        if (i_ctl.stripe_init) begin
            r_left <= (i_elem_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : i_elem_count;
            r_home <= '0;
        end else if (i_ctl.el_step) begin
            r_left <= r_left - 1'b1;
            if (!s_novf && s_home_hit) begin
                r_home <= r_home + HOME_SUM_W'(r_size);
            end
        end
        if (i_ctl.el_step && s_el_last) begin
            r_pend_addr <= s_ptr;
            r_pend_ovf  <= s_novf;
        end
    end

    // Result register: a new item may enter when it is empty or being taken.
    assign s_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.loc_emit || i_ctl.pop_emit || s_el_emit || i_ctl.fin_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.loc_emit) begin
            r_out_addr <= i_cfg.local_base + r_local_next;
            r_out_last <= 1'b1;
            r_out_ovf  <= s_lsum[ADDR_W];
        end else if (i_ctl.pop_emit) begin
            r_out_addr <= s_ring_q;
            r_out_last <= 1'b1;
            r_out_ovf  <= 1'b0;
        end else if (s_el_emit) begin
            r_out_addr <= s_ptr;
            r_out_last <= 1'b0;
            r_out_ovf  <= s_novf;
        end else if (i_ctl.fin_emit) begin
            r_out_addr <= r_pend_addr;
            r_out_last <= 1'b1;
            r_out_ovf  <= r_pend_ovf || s_fovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_address   = r_out_addr;
    assign o_last      = r_out_last;
    assign o_overflow  = r_out_ovf;

    assign o_stat.cmd         = i_cmd;
    assign o_stat.cnt_zero    = (i_elem_count == '0);
    assign o_stat.ring_gt_min = (r_cnt > CW'(RING_MIN));
    assign o_stat.el_last     = s_el_last;
    assign o_stat.out_free    = s_out_free;
endmodule
